// ===== rtl/core/gsps_pkg.sv =====
// Package for the gas sensor poll sequencer: delay constants, error codes
// and the CRC-8 helpers used by the core. No dependencies.
package gsps_pkg;

   // CRC-8 of the sensor bus words: polynomial 0x31, start 0xff, no reflection
   localparam logic [7:0] CrcPoly = 8'h31;
   localparam logic [7:0] CrcInit = 8'hff;

   // Expected self-test answer, first byte
   localparam logic [7:0] BistPass = 8'hd4;
   // Version words with any of these high-byte bits set are not stored
   localparam logic [7:0] VersionMask = 8'hd0;

   // Step commands
   localparam logic [1:0] CmdStep    = 2'd0;
   localparam logic [1:0] CmdRestart = 2'd1;
   localparam logic [1:0] CmdStop    = 2'd2;

   // Error codes
   localparam logic [1:0] ErrNone = 2'd0;
   localparam logic [1:0] ErrBus  = 2'd1;
   localparam logic [1:0] ErrCrc  = 2'd2;
   localparam logic [1:0] ErrResp = 2'd3;

   // Delays to the next step, in milliseconds
   localparam logic [12:0] DelayShort   = 13'd10;
   localparam logic [12:0] DelayInit    = 13'd20;
   localparam logic [12:0] DelayIdle    = 13'd50;
   localparam logic [12:0] DelayBist    = 13'd250;
   localparam logic [12:0] DelayRead    = 13'd975;
   localparam logic [12:0] DelayUnused  = 13'd1000;
   localparam logic [12:0] DelayRetry   = 13'd3000;
   localparam logic [12:0] DelayFailure = 13'd5000;

   // One byte through the CRC register, msb first
   function automatic logic [7:0] crc_byte(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] c;
      c = crc ^ data;
      for (int i = 0; i < 8; i++) begin
         c = c[7] ? ({c[6:0], 1'b0} ^ CrcPoly) : {c[6:0], 1'b0};
      end
      return c;
   endfunction

   // CRC of a two-byte word, high byte first
   function automatic logic [7:0] crc_pair(input logic [7:0] hi, input logic [7:0] lo);
      return crc_byte(crc_byte(CrcInit, hi), lo);
   endfunction

endpackage

// ===== rtl/core/gas_sensor_poll_sequencer_core.sv =====
// Gas sensor poll sequencer: state walk, CRC checks and result register.
// Depends on gsps_pkg.
//
//  channel | direction | handshake          | payload
//  req_    | in        | req_valid/req_stall | cmd, bus_fail, rx_byte0..5, abs_humidity
//  rsp_    | out       | rsp_valid/rsp_stall | fsm_state, delay, readings, version, error, humidity write
//
// An input register, then one pass of sequencer logic into the result register.
// One item per cycle is sustained unless stalled; the rate is set by that pass.
// Sequencer state is updated as an item moves from the input to the result register.
// Synchronous reset clears valids and sequencer state. A stalled result holds; the
// input register still takes one item behind it, then req_stall follows rsp_stall.
module gas_sensor_poll_sequencer_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_cmd,
   input  logic        req_bus_fail,
   input  logic [7:0]  req_rx_byte0,
   input  logic [7:0]  req_rx_byte1,
   input  logic [7:0]  req_rx_byte2,
   input  logic [7:0]  req_rx_byte3,
   input  logic [7:0]  req_rx_byte4,
   input  logic [7:0]  req_rx_byte5,
   input  logic [7:0]  req_abs_humidity,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [3:0]  rsp_fsm_state,
   output logic [12:0] rsp_delay_ms,
   output logic        rsp_values_update,
   output logic [15:0] rsp_co2_ppm,
   output logic        rsp_co2_valid,
   output logic [15:0] rsp_tvoc_ppb,
   output logic        rsp_tvoc_valid,
   output logic [15:0] rsp_version_word,
   output logic [1:0]  rsp_error_code,
   output logic        rsp_humid_write,
   output logic [15:0] rsp_humid_word,
   output logic [7:0]  rsp_humid_crc
);

   typedef enum logic [3:0] {
      S_NONE    = 4'd0,
      S_INIT    = 4'd1,
      S_BIST    = 4'd2,
      S_GETS    = 4'd3,
      S_GETV    = 4'd4,
      S_READB   = 4'd5,
      S_READD   = 4'd6,
      S_READS   = 4'd7,
      S_READV   = 4'd8,
      S_IAQ     = 4'd9,
      S_IDLE    = 4'd10,
      S_UPDATE  = 4'd11,
      S_MEASURE = 4'd12,
      S_ERROR   = 4'd13
   } state_type;

   // Input register
   logic       in_valid_ff;
   logic [1:0] cmd_ff;
   logic       bus_fail_ff;
   logic [7:0] b0_ff, b1_ff, b2_ff, b3_ff, b4_ff, b5_ff;
   logic [7:0] hum_ff;

   // Sequencer state. The self-test flag is never set and the IAQ flag is only
   // consulted behind it, so only the version and serial flags are kept.
   // Humidity only ever takes 8-bit values, so the last one is held in 8 bits.
   state_type  state_ff, state_in;
   logic       ver_done_ff, ver_done_in;
   logic       ser_done_ff, ser_done_in;
   logic [7:0] last_hum_ff, last_hum_in;
   logic [15:0] version_ff, version_in;
   logic [1:0] last_err_ff, last_err_in;

   // Result register
   logic        out_valid_ff;
   logic [3:0]  fsm_state_ff;
   logic [12:0] delay_ff, delay_in;
   logic        vu_ff, vu_in;
   logic [15:0] co2_ff, co2_in;
   logic        co2v_ff, co2v_in;
   logic [15:0] tvoc_ff, tvoc_in;
   logic        tvocv_ff, tvocv_in;
   logic        hw_ff, hw_in;
   logic [15:0] hword_ff, hword_in;
   logic [7:0]  hcrc_ff, hcrc_in;

   logic out_free, advance;
   logic failed;
   logic [1:0] err;
   logic [7:0] crc_w0, crc_w1, crc_hum;

   // Handshake: the result register frees when empty or taken
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;

   assign crc_w0  = gsps_pkg::crc_pair(b0_ff, b1_ff);
   assign crc_w1  = gsps_pkg::crc_pair(b3_ff, b4_ff);
   assign crc_hum = gsps_pkg::crc_pair(8'h00, hum_ff);

   // Next state and result for the item in the input register
   always_comb begin
      state_in    = state_ff;
      ver_done_in = ver_done_ff;
      ser_done_in = ser_done_ff;
      last_hum_in = last_hum_ff;
      version_in  = version_ff;
      last_err_in = last_err_ff;
      delay_in    = '0;
      vu_in       = 1'b0;
      co2_in      = '0;
      co2v_in     = 1'b0;
      tvoc_in     = '0;
      tvocv_in    = 1'b0;
      hw_in       = 1'b0;
      hword_in    = '0;
      hcrc_in     = '0;
      failed      = 1'b0;
      err         = gsps_pkg::ErrNone;

      if (cmd_ff == gsps_pkg::CmdRestart) begin
         state_in = S_INIT;
         delay_in = gsps_pkg::DelayInit;
      end else if (cmd_ff == gsps_pkg::CmdStop) begin
         state_in = S_IDLE;
         delay_in = gsps_pkg::DelayIdle;
      end else begin
         unique case (state_ff)
            S_INIT: begin
               if (!ver_done_ff)      state_in = S_GETV;
               else if (!ser_done_ff) state_in = S_GETS;
               else                   state_in = S_BIST;
               delay_in = gsps_pkg::DelayInit;
            end
            S_BIST: begin
               if (bus_fail_ff) begin
                  failed = 1'b1; err = gsps_pkg::ErrBus;
               end else begin
                  state_in = S_READB; delay_in = gsps_pkg::DelayBist;
               end
            end
            S_GETS: begin
               // bus failure ignored here
               state_in = S_READS; delay_in = gsps_pkg::DelayShort;
            end
            S_GETV: begin
               if (bus_fail_ff) begin
                  failed = 1'b1; err = gsps_pkg::ErrBus;
               end else begin
                  state_in = S_READV; delay_in = gsps_pkg::DelayShort;
               end
            end
            S_READB: begin
               if (bus_fail_ff) begin
                  failed = 1'b1; err = gsps_pkg::ErrBus;
               end else if (b0_ff != gsps_pkg::BistPass || b1_ff != 8'h00) begin
                  failed = 1'b1; err = gsps_pkg::ErrResp;
               end else if (crc_w0 != b2_ff) begin
                  failed = 1'b1; err = gsps_pkg::ErrCrc;
               end else begin
                  state_in = S_IAQ; delay_in = gsps_pkg::DelayShort;
               end
            end
            S_READD: begin
               if (bus_fail_ff) begin
                  failed = 1'b1; err = gsps_pkg::ErrBus;
               end else begin
                  vu_in = 1'b1;
                  if (crc_w0 == b2_ff) begin
                     co2v_in = 1'b1; co2_in = {b0_ff, b1_ff};
                  end
                  if (crc_w1 == b5_ff) begin
                     tvocv_in = 1'b1; tvoc_in = {b3_ff, b4_ff};
                  end
                  state_in = S_UPDATE; delay_in = gsps_pkg::DelayRead;
               end
            end
            S_READS: begin
               // serial bytes are not checked
               if (bus_fail_ff) begin
                  failed = 1'b1; err = gsps_pkg::ErrBus;
               end else begin
                  ser_done_in = 1'b1; state_in = S_INIT; delay_in = gsps_pkg::DelayShort;
               end
            end
            S_READV: begin
               if (bus_fail_ff) begin
                  failed = 1'b1; err = gsps_pkg::ErrBus;
               end else if (crc_w0 != b2_ff) begin
                  failed = 1'b1; err = gsps_pkg::ErrCrc;
               end else begin
                  if ((b1_ff & gsps_pkg::VersionMask) == 8'h00) version_in = {b1_ff, b0_ff};
                  ver_done_in = 1'b1; state_in = S_INIT; delay_in = gsps_pkg::DelayShort;
               end
            end
            S_IDLE: delay_in = gsps_pkg::DelayIdle;
            S_UPDATE: begin
               // write issued on a change, even if the transfer then fails
               if (hum_ff != last_hum_ff) begin
                  last_hum_in = hum_ff;
                  hw_in       = 1'b1;
                  hword_in    = {8'h00, hum_ff};
                  hcrc_in     = crc_hum;
                  if (bus_fail_ff) begin
                     failed = 1'b1; err = gsps_pkg::ErrBus;
                  end
               end
               if (!failed) begin
                  state_in = S_MEASURE; delay_in = gsps_pkg::DelayShort;
               end
            end
            S_IAQ: begin
               if (bus_fail_ff) begin
                  failed = 1'b1; err = gsps_pkg::ErrBus;
               end else begin
                  state_in = S_MEASURE; delay_in = gsps_pkg::DelayShort;
               end
            end
            S_MEASURE: begin
               if (bus_fail_ff) begin
                  failed = 1'b1; err = gsps_pkg::ErrBus;
               end else begin
                  state_in = S_READD; delay_in = gsps_pkg::DelayInit;
               end
            end
            S_ERROR: begin
               state_in = S_INIT; delay_in = gsps_pkg::DelayRetry;
            end
            default: delay_in = gsps_pkg::DelayUnused;
         endcase

         // any failure: record it, drop the readings, back off
         if (failed) begin
            last_err_in = err;
            state_in    = S_ERROR;
            vu_in       = 1'b1;
            co2_in      = '0;
            co2v_in     = 1'b0;
            tvoc_in     = '0;
            tvocv_in    = 1'b0;
            delay_in    = gsps_pkg::DelayFailure;
         end
      end
   end

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
      if (req_valid && !req_stall) begin
         cmd_ff      <= req_cmd;
         bus_fail_ff <= req_bus_fail;
         b0_ff       <= req_rx_byte0;
         b1_ff       <= req_rx_byte1;
         b2_ff       <= req_rx_byte2;
         b3_ff       <= req_rx_byte3;
         b4_ff       <= req_rx_byte4;
         b5_ff       <= req_rx_byte5;
         hum_ff      <= req_abs_humidity;
      end
   end

   // Sequencer state and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         ver_done_ff  <= 1'b0;
         ser_done_ff  <= 1'b0;
         last_hum_ff  <= '0;
         version_ff   <= '0;
         last_err_ff  <= gsps_pkg::ErrNone;
         out_valid_ff <= 1'b0;
      end else begin
         if (out_free) out_valid_ff <= in_valid_ff;
         if (advance) begin
            state_ff    <= state_in;
            ver_done_ff <= ver_done_in;
            ser_done_ff <= ser_done_in;
            last_hum_ff <= last_hum_in;
            version_ff  <= version_in;
            last_err_ff <= last_err_in;
         end
      end
      if (advance) begin
         fsm_state_ff <= state_in;
         delay_ff     <= delay_in;
         vu_ff        <= vu_in;
         co2_ff       <= co2_in;
         co2v_ff      <= co2v_in;
         tvoc_ff      <= tvoc_in;
         tvocv_ff     <= tvocv_in;
         hw_ff        <= hw_in;
         hword_ff     <= hword_in;
         hcrc_ff      <= hcrc_in;
      end
   end

   // Version and error are the stored values after the step
   logic [15:0] version_out_ff;
   logic [1:0]  err_out_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         version_out_ff <= version_in;
         err_out_ff     <= last_err_in;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_fsm_state     = fsm_state_ff;
   assign rsp_delay_ms      = delay_ff;
   assign rsp_values_update = vu_ff;
   assign rsp_co2_ppm       = co2_ff;
   assign rsp_co2_valid     = co2v_ff;
   assign rsp_tvoc_ppb      = tvoc_ff;
   assign rsp_tvoc_valid    = tvocv_ff;
   assign rsp_version_word  = version_out_ff;
   assign rsp_error_code    = err_out_ff;
   assign rsp_humid_write   = hw_ff;
   assign rsp_humid_word    = hword_ff;
   assign rsp_humid_crc     = hcrc_ff;

endmodule

// ===== rtl/core/gsps_checker.sv =====
// Port-level checks for the gas sensor poll sequencer core, bound into the core module.
// Depends on gas_sensor_poll_sequencer_core.
module gsps_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic        rsp_values_update,
   input logic [15:0] rsp_co2_ppm,
   input logic        rsp_co2_valid,
   input logic [15:0] rsp_tvoc_ppb,
   input logic        rsp_tvoc_valid,
   input logic        rsp_humid_write,
   input logic [15:0] rsp_humid_word,
   input logic [7:0]  rsp_humid_crc
);

   // a stalled result stays offered
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result dropped while stalled");

   // input side only backs up behind a blocked result
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without a blocked result");

   // readings stay clear unless this step set them
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_values_update |->
         rsp_co2_ppm == 16'h0 && !rsp_co2_valid && rsp_tvoc_ppb == 16'h0 && !rsp_tvoc_valid)
      else $error("readings set without an update");

   // no humidity write: word and CRC are clear
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_humid_write |-> rsp_humid_word == 16'h0 && rsp_humid_crc == 8'h0)
      else $error("humidity word without a write");

endmodule

bind gas_sensor_poll_sequencer_core gsps_checker u_gsps_checker (
   .clock             (clock),
   .reset             (reset),
   .req_stall         (req_stall),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_values_update (rsp_values_update),
   .rsp_co2_ppm       (rsp_co2_ppm),
   .rsp_co2_valid     (rsp_co2_valid),
   .rsp_tvoc_ppb      (rsp_tvoc_ppb),
   .rsp_tvoc_valid    (rsp_tvoc_valid),
   .rsp_humid_write   (rsp_humid_write),
   .rsp_humid_word    (rsp_humid_word),
   .rsp_humid_crc     (rsp_humid_crc)
);
